/* hw/rtl/lpfd_pkg.sv */
// Shared types and constants for the length-prefixed frame decoder.
package lpfd_pkg;

    localparam int unsigned LENGTH_BYTES_DEF = 4;
    localparam int unsigned MAX_PAYLOAD_W    = 32;
    localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RST = 32'd1048576;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;

    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_PAYLOAD = 2'd0;
    localparam t_status ST_EMPTY   = 2'd1;
    localparam t_status ST_ERROR   = 2'd2;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_TYPE,
        PH_PAY,
        PH_ERR
    } t_phase;

endpackage

/* hw/rtl/length_prefixed_frame_decoder.sv */
// A result appears on the output register in the cycle after its byte is taken.
// Throughput: one byte per cycle; the input stalls only while a held result is stalled.
// Each byte passes through one length compare or counter decrement into the result register.
// Reset (synchronous, active low): decoder waits for the first length byte, max_payload
// returns to 1048576, the output register is emptied.
module length_prefixed_frame_decoder #(
    parameter int unsigned LENGTH_BYTES = lpfd_pkg::LENGTH_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lpfd_pkg::MAX_PAYLOAD_W-1:0] i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  lpfd_pkg::t_byte                    i_in_byte,
    output logic                               o_valid,
    input  logic                               i_stall,
    output lpfd_pkg::t_status                  o_status,
    output lpfd_pkg::t_byte                    o_msg_type,
    output lpfd_pkg::t_byte                    o_payload_byte,
    output logic                               o_frame_last
);
    import lpfd_pkg::*;

    localparam int unsigned LEN_W = BYTE_W * LENGTH_BYTES;
    localparam int unsigned CMP_W = (LEN_W > MAX_PAYLOAD_W) ? LEN_W : MAX_PAYLOAD_W;
    localparam int unsigned IDX_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LENGTH_BYTES - 1);

    logic [MAX_PAYLOAD_W-1:0] r_max_payload;

    t_phase            r_phase,   n_phase;
    logic [IDX_W-1:0]  r_len_idx, n_len_idx;
    logic [LEN_W-1:0]  r_accum,   n_accum;
    logic [LEN_W-1:0]  r_left,    n_left;
    t_byte             r_type,    n_type;

    logic              r_out_valid, n_out_valid;
    t_status           r_status,  n_status;
    t_byte             r_msg_type, n_msg_type;
    t_byte             r_pay,     n_pay;
    logic              r_last,    n_last;

    logic              accept;
    logic              produce;
    logic [LEN_W-1:0]  len_full;
    logic [LEN_W-1:0]  len_m1;
    logic              len_bad;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // the full length as it stands once the current byte is shifted in
    assign len_full = LEN_W'({r_accum, i_in_byte});
    assign len_m1   = len_full - LEN_W'(1);
    assign len_bad  = (len_full == '0) || (CMP_W'(len_m1) > CMP_W'(r_max_payload));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEN;
            r_len_idx   <= '0;
            r_accum     <= '0;
            r_left      <= '0;
            r_type      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_len_idx   <= n_len_idx;
            r_accum     <= n_accum;
            r_left      <= n_left;
            r_type      <= n_type;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_msg_type <= n_msg_type;
        r_pay      <= n_pay;
        r_last     <= n_last;
    end

    always_comb begin
        n_phase    = r_phase;
        n_len_idx  = r_len_idx;
        n_accum    = r_accum;
        n_left     = r_left;
        n_type     = r_type;
        produce    = 1'b0;
        n_status   = r_status;
        n_msg_type = r_msg_type;
        n_pay      = r_pay;
        n_last     = r_last;

        if (accept) begin
            case (r_phase)
                PH_LEN: begin
                    n_accum   = len_full;
                    n_len_idx = r_len_idx + IDX_W'(1);
                    if (r_len_idx == IDX_LAST) begin
                        if (len_bad) begin
                            n_phase    = PH_ERR;
                            produce    = 1'b1;
                            n_status   = ST_ERROR;
                            n_msg_type = '0;
                            n_pay      = '0;
                            n_last     = 1'b0;
                        end else begin
                            n_left  = len_m1;
                            n_phase = PH_TYPE;
                        end
                    end
                end
                PH_TYPE: begin
                    n_type = i_in_byte;
                    if (r_left == '0) begin
                        produce    = 1'b1;
                        n_status   = ST_EMPTY;
                        n_msg_type = i_in_byte;
                        n_pay      = '0;
                        n_last     = 1'b1;
                        // start the next frame
                        n_phase    = PH_LEN;
                        n_len_idx  = '0;
                        n_accum    = '0;
                    end else begin
                        n_phase = PH_PAY;
                    end
                end
                PH_PAY: begin
                    produce    = 1'b1;
                    n_status   = ST_PAYLOAD;
                    n_msg_type = r_type;
                    n_pay      = i_in_byte;
                    n_last     = (r_left == LEN_W'(1));
                    n_left     = r_left - LEN_W'(1);
                    if (r_left == LEN_W'(1)) begin
                        n_phase   = PH_LEN;
                        n_len_idx = '0;
                        n_accum   = '0;
                    end
                end
                default: begin
                    // sticky error: report on every byte until reset
                    n_phase    = PH_ERR;
                    produce    = 1'b1;
                    n_status   = ST_ERROR;
                    n_msg_type = '0;
                    n_pay      = '0;
                    n_last     = 1'b0;
                end
            endcase
        end

        // hold a stalled result, drop a taken one
        if (produce) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_stall) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_msg_type     = r_msg_type;
    assign o_payload_byte = r_pay;
    assign o_frame_last   = r_last;

endmodule

/* hw/rtl/lpfd_checker.sv */
// Port-level checks for the length-prefixed frame decoder, bound to the top level.
module lpfd_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_stall,
    input  logic              o_valid,
    input  logic              i_stall,
    input  lpfd_pkg::t_status o_status,
    input  lpfd_pkg::t_byte   o_msg_type,
    input  lpfd_pkg::t_byte   o_payload_byte,
    input  logic              o_frame_last
);
    import lpfd_pkg::*;

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_msg_type)
                               && $stable(o_payload_byte) && $stable(o_frame_last))
        else $error("stalled result changed");

    // the input only stalls behind a held result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output register");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_ERROR |-> o_msg_type == '0 && o_payload_byte == '0
                                            && !o_frame_last)
        else $error("error transaction carries data");

    a_empty_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_frame_last && o_payload_byte == '0)
        else $error("empty-frame marker not closing its frame");

    // a valid result right after a shown error result is also an error
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_valid && o_status == ST_ERROR) && o_valid |-> o_status == ST_ERROR)
        else $error("decoder left the error state without reset");

endmodule

bind length_prefixed_frame_decoder lpfd_checker u_lpfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_msg_type     (o_msg_type),
    .o_payload_byte (o_payload_byte),
    .o_frame_last   (o_frame_last)
);

/* dv/length_prefixed_frame_decoder_tb.sv */
// Self-checking testbench for the length-prefixed frame decoder.
`timescale 1ns / 1ps

module length_prefixed_frame_decoder_tb;
    import lpfd_pkg::*;

    localparam int unsigned LEN_BYTES      = LENGTH_BYTES_DEF;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned MAX_REPORTS     = 40;

    typedef struct packed {
        t_status status;
        t_byte   msg_type;
        t_byte   payload_byte;
        logic    frame_last;
    } t_frame_result;

    typedef enum int {
        RX_FLOW,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    typedef enum int {
        BAD_ZERO,
        BAD_ONE_OVER,
        BAD_HUGE
    } t_bad_length;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_cfg_we       = 1'b0;
    logic [MAX_PAYLOAD_W-1:0] i_cfg_data     = '0;
    logic                     i_valid        = 1'b0;
    t_byte                    i_in_byte      = '0;
    logic                     i_stall        = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    t_status                  o_status;
    t_byte                    o_msg_type;
    t_byte                    o_payload_byte;
    logic                     o_frame_last;

    length_prefixed_frame_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_msg_type     (o_msg_type),
        .o_payload_byte (o_payload_byte),
        .o_frame_last   (o_frame_last)
    );

    always #5 i_clk = ~i_clk;

    // Decoder shadow state
    t_phase                   dec_phase     = PH_LEN;
    int unsigned              len_count     = 0;
    logic [31:0]              len_accum     = '0;
    logic [31:0]              left_count    = '0;
    t_byte                    held_type     = '0;
    logic [MAX_PAYLOAD_W-1:0] max_pay_cfg   = MAX_PAYLOAD_RST;

    t_frame_result expected_results[$];

    int unsigned mismatch_count  = 0;
    int unsigned results_checked = 0;
    int unsigned bytes_sent      = 0;
    int unsigned frames_sent     = 0;
    int unsigned cfg_settings    = 1;

    // Sender and receiver pacing
    int unsigned burst_left     = 0;
    bit          gaps_enabled   = 1'b1;
    bit          hold_off_req   = 1'b0;
    int unsigned hold_off_left  = 0;
    int unsigned rx_cycle       = 0;
    t_rx_mode    rx_mode        = RX_FLOW;

    function automatic void restart_frame();
        dec_phase  = PH_LEN;
        len_count  = 0;
        len_accum  = '0;
        left_count = '0;
    endfunction

    function automatic void push_result(t_status st, t_byte ty, t_byte pb, logic last);
        t_frame_result r;
        r.status       = st;
        r.msg_type     = ty;
        r.payload_byte = pb;
        r.frame_last   = last;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Advance the shadow decoder by one accepted byte and queue its result, if any
    function automatic void decode_stream_byte(t_byte b);
        case (dec_phase)
            PH_LEN: begin
                len_accum = {len_accum[23:0], b};
                len_count++;
                if (len_count == LEN_BYTES) begin
                    len_count = 0;
                    if (len_accum == 0 || (len_accum - 32'd1) > max_pay_cfg) begin
                        dec_phase = PH_ERR;
                        push_result(ST_ERROR, '0, '0, 1'b0);
                    end else begin
                        left_count = len_accum - 32'd1;
                        dec_phase  = PH_TYPE;
                    end
                end
            end
            PH_TYPE: begin
                held_type = b;
                if (left_count == 0) begin
                    push_result(ST_EMPTY, b, '0, 1'b1);
                    restart_frame();
                end else begin
                    dec_phase = PH_PAY;
                end
            end
            PH_PAY: begin
                push_result(ST_PAYLOAD, held_type, b, left_count == 32'd1);
                left_count--;
                if (left_count == 0)
                    restart_frame();
            end
            default: begin
                push_result(ST_ERROR, '0, '0, 1'b0);
            end
        endcase
    endfunction

    // Receiver: stall on a pattern of its own, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_off_req) begin
            hold_off_req  = 1'b0;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        rx_cycle++;
        if (hold_off_left != 0) begin
            hold_off_left--;
            i_stall <= 1'b1;
        end else begin
            if (rx_cycle % 80 == 0)
                rx_mode = t_rx_mode'($urandom_range(0, 3));
            case (rx_mode)
                RX_FLOW:  i_stall <= 1'b0;
                RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_stall <= ($urandom_range(0, 9) < 7);
                default:  i_stall <= ((rx_cycle % 5) < 2);
            endcase
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // Compare each output transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display({"%0t: unexpected result, expected none ",
                              "actual status %0d type %0d data %0d last %0d"},
                             $time, o_status, o_msg_type, o_payload_byte, o_frame_last);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("msg_type", 32'(want.msg_type), 32'(o_msg_type));
                check_field("payload_byte", 32'(want.payload_byte), 32'(o_payload_byte));
                check_field("frame_last", 32'(want.frame_last), 32'(o_frame_last));
            end
        end
    end

    task automatic send_byte(input t_byte b);
        i_valid   <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_stall);
        decode_stream_byte(b);
        bytes_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_enabled && $urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_length(input logic [31:0] len);
        for (int k = LEN_BYTES - 1; k >= 0; k--)
            send_byte(t_byte'(len >> (8 * k)));
    endtask

    function automatic t_byte random_data_byte();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return t_byte'($urandom);
    endfunction

    task automatic send_frame(input int unsigned pay_count);
        send_length(pay_count + 1);
        send_byte(random_data_byte());
        for (int unsigned n = 0; n < pay_count; n++)
            send_byte(random_data_byte());
        frames_sent++;
    endtask

    // Mostly short frames, now and then an empty one, one at the limit or a long one
    function automatic int unsigned pick_pay_count(logic [31:0] cap);
        int unsigned top;
        int unsigned r;
        top = (cap > 300) ? 300 : int'(cap);
        if (top == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 15)
            return (cap <= 300) ? top : $urandom_range(100, 300);
        if (r < 20)
            return $urandom_range((top > 100) ? 100 : 1, top);
        return $urandom_range(1, (top < 24) ? top : 24);
    endfunction

    task automatic wait_idle();
        int unsigned guard;
        guard = 0;
        i_valid <= 1'b0;
        while (expected_results.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_payload(input logic [MAX_PAYLOAD_W-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        max_pay_cfg = value;
        cfg_settings++;
    endtask

    task automatic run_random_frames(input int unsigned budget);
        int unsigned stop_at;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 19) == 0)
                gaps_enabled = ~gaps_enabled;
            send_frame(pick_pay_count(max_pay_cfg));
        end
        gaps_enabled = 1'b1;
    endtask

    // Empty frames and short payloads on the reset limit, data at both extremes
    task automatic test_directed_frames();
        send_length(32'd1);
        send_byte(8'h00);
        send_length(32'd1);
        send_byte(8'hFF);
        send_length(32'd3);
        send_byte(8'hA5);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_length(32'd2);
        send_byte(8'h3C);
        send_byte(8'h80);
        frames_sent += 4;
    endtask

    task automatic test_reset_limit();
        run_random_frames(500);
    endtask

    // Zero limit lets only empty frames through
    task automatic test_zero_limit();
        write_max_payload('0);
        run_random_frames(200);
    endtask

    // Small limit, frames land on the limit often
    task automatic test_small_limit();
        write_max_payload(32'd5);
        for (int unsigned n = 0; n <= 5; n++)
            send_frame(n);
        run_random_frames(300);
    endtask

    task automatic test_top_limit();
        write_max_payload(32'hFFFF_FFFE);
        run_random_frames(300);
    endtask

    task automatic test_random_limit();
        write_max_payload($urandom_range(1, 64));
        run_random_frames(300);
    endtask

    // Hold the output off while a long frame is offered, so the input stalls
    task automatic test_output_hold_off();
        wait_idle();
        gaps_enabled = 1'b0;
        hold_off_req = 1'b1;
        send_frame(max_pay_cfg < 200 ? int'(max_pay_cfg) : 200);
        send_frame(pick_pay_count(max_pay_cfg));
        gaps_enabled = 1'b1;
    endtask

    // Bad length drops the decoder into the sticky error state; noise follows
    task automatic test_bad_length_sticky();
        t_bad_length        kind;
        logic [31:0]        bad_len;
        write_max_payload($urandom_range(0, 40));
        for (int unsigned n = 0; n < 4; n++)
            send_frame(pick_pay_count(max_pay_cfg));
        kind = t_bad_length'($urandom_range(0, 2));
        case (kind)
            BAD_ZERO:     bad_len = '0;
            BAD_ONE_OVER: bad_len = max_pay_cfg + 32'd2;
            default:      bad_len = $urandom | 32'h8000_0000;
        endcase
        send_length(bad_len);
        for (int unsigned n = 0; n < 60; n++)
            send_byte(t_byte'($urandom));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_frames();
        test_reset_limit();
        test_zero_limit();
        test_small_limit();
        test_output_hold_off();
        test_top_limit();
        test_random_limit();
        test_bad_length_sticky();
        wait_idle();
        if (expected_results.size() != 0) begin
            mismatch_count += expected_results.size();
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
        end
        $display("Run covered %0d bytes in %0d frames, %0d results checked, %0d payload limits.",
                 bytes_sent, frames_sent, results_checked, cfg_settings);
        $display({"Included empty frames, frames at the limit, a long output hold-off ",
                  "and a sticky bad length."});
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* length_prefixed_frame_decoder.f */
hw/rtl/lpfd_pkg.sv
hw/rtl/length_prefixed_frame_decoder.sv
hw/rtl/lpfd_checker.sv
dv/length_prefixed_frame_decoder_tb.sv
